// ===== design/mac_pkg.sv =====
// Shared types and constants of the moving-average crossover counter.
package mac_pkg;

    localparam int CFG_BITS       = 7;
    localparam int CFG_INDEX_BITS = 2;
    localparam int COUNT_BITS     = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_A = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_B = 2'd1;

    localparam logic [CFG_BITS-1:0] WINDOW_A_RESET = 7'd1;
    localparam logic [CFG_BITS-1:0] WINDOW_B_RESET = 7'd2;

    typedef enum logic [1:0] {
        REL_NONE  = 2'd0,
        REL_ABOVE = 2'd1,
        REL_BELOW = 2'd2,
        REL_EQUAL = 2'd3
    } t_relation;

endpackage

// ===== design/mac_ram.sv =====
// Generic RAM with one write port and two registered read ports, old data on collision.
module mac_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== design/moving_average_crossover_counter.sv =====
// Top level of the moving-average crossover counter.
// The block takes one sample per clock cycle while o_stall is low. At the transfer the history
// RAM is read and the sample is registered in stage 1; the window sums are then updated as the
// sample moves into stage 2, where the exact cross-multiplied mean comparison and the crossing
// count are done before the output register. The sustained rate of one sample per cycle is set
// by the sum update loop and the relation and count loop, each a loop on its own registers. The shorter of
// the two window lengths is the short window; a length of zero is taken as one and a length above
// MAX_WINDOW as MAX_WINDOW. Writing either window register clears the sums, the fill count and the
// previous relation but keeps the crossing total; a sample with restart set clears all of these.
module moving_average_crossover_counter
    import mac_pkg::*;
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                      i_restart,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [1:0]                o_relation,
    output logic                      o_crossed,
    output logic [COUNT_BITS-1:0]     o_crossings_total,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]       i_cfg_data
);

    localparam int ADDR_W = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W  = LEN_W + 1;
    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int PROD_W = SUM_W + LEN_W + 1;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_BITS-1:0] v);
        if (v == '0) begin
            clamp_len = LEN_W'(1);
        end else if (int'(v) > MAX_WINDOW) begin
            clamp_len = LEN_W'(MAX_WINDOW);
        end else begin
            clamp_len = LEN_W'(v);
        end
    endfunction

    function automatic logic [ADDR_W-1:0] ago_addr(input logic [ADDR_W-1:0] pos,
                                                   input logic [LEN_W-1:0] len);
        logic [PTR_W-1:0] p;
        logic [PTR_W-1:0] d;
        p = PTR_W'(pos);
        if (p >= PTR_W'(len)) begin
            d = p - PTR_W'(len);
        end else begin
            d = p + PTR_W'(MAX_WINDOW) - PTR_W'(len);
        end
        ago_addr = d[ADDR_W-1:0];
    endfunction

    logic [CFG_BITS-1:0] r_window_a;
    logic [CFG_BITS-1:0] r_window_b;
    logic                cfg_write;
    logic                clear_seq;

    logic [LEN_W-1:0] len_a;
    logic [LEN_W-1:0] len_b;
    logic [LEN_W-1:0] s_len;
    logic [LEN_W-1:0] l_len;

    logic adv_o;
    logic adv2;
    logic adv1;
    logic accept;
    logic move1;
    logic move2;

    logic [ADDR_W-1:0] r_wr_pos;
    logic [ADDR_W-1:0] n_wr_pos;

    logic [SAMPLE_BITS-1:0] rd_short;
    logic [SAMPLE_BITS-1:0] rd_long;

    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic                          r_s1_restart;

    logic signed [SUM_W-1:0] r_short_sum;
    logic signed [SUM_W-1:0] r_long_sum;
    logic [LEN_W-1:0]        r_seen;

    logic signed [SUM_W-1:0] base_short;
    logic signed [SUM_W-1:0] base_long;
    logic [LEN_W-1:0]        base_seen;
    logic signed [SUM_W:0]   drop_short;
    logic signed [SUM_W:0]   drop_long;
    logic signed [SUM_W:0]   ext_short;
    logic signed [SUM_W:0]   ext_long;
    logic signed [SUM_W-1:0] n_short_sum;
    logic signed [SUM_W-1:0] n_long_sum;
    logic [LEN_W-1:0]        n_seen;

    logic                    r_s2_valid;
    logic signed [SUM_W-1:0] r_s2_short;
    logic signed [SUM_W-1:0] r_s2_long;
    logic                    r_s2_full;
    logic                    r_s2_restart;

    logic signed [LEN_W:0]  s_len_s;
    logic signed [LEN_W:0]  l_len_s;
    logic signed [PROD_W-1:0] lhs;
    logic signed [PROD_W-1:0] rhs;
    t_relation cmp_rel;
    t_relation n_rel;
    t_relation prev_rel;
    t_relation r_prev_rel;
    logic                  n_crossed;
    logic [COUNT_BITS-1:0] base_count;
    logic [COUNT_BITS-1:0] n_count;
    logic [COUNT_BITS-1:0] r_count;

    logic                  r_o_valid;
    t_relation             r_o_relation;
    logic                  r_o_crossed;
    logic [COUNT_BITS-1:0] r_o_total;

    // Configuration
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid;
    assign clear_seq   = cfg_write && (i_cfg_index == REG_WINDOW_A || i_cfg_index == REG_WINDOW_B);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_a <= WINDOW_A_RESET;
            r_window_b <= WINDOW_B_RESET;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                REG_WINDOW_A: r_window_a <= i_cfg_data;
                REG_WINDOW_B: r_window_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign len_a = clamp_len(r_window_a);
    assign len_b = clamp_len(r_window_b);
    assign s_len = (len_a < len_b) ? len_a : len_b;
    assign l_len = (len_a < len_b) ? len_b : len_a;

    // Pipeline flow control
    assign adv_o   = !r_o_valid || !i_stall;
    assign adv2    = !r_s2_valid || adv_o;
    assign adv1    = !r_s1_valid || adv2;
    assign accept  = i_valid && adv1;
    assign move1   = r_s1_valid && adv2;
    assign move2   = r_s2_valid && adv_o;
    assign o_stall = !adv1;

    // History line
    assign n_wr_pos = (r_wr_pos == ADDR_W'(MAX_WINDOW - 1)) ? '0 : r_wr_pos + ADDR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
        end else if (accept) begin
            r_wr_pos <= n_wr_pos;
        end
    end

    mac_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_history (
        .i_clk     (i_clk),
        .i_we      (accept),
        .i_waddr   (r_wr_pos),
        .i_wdata   (i_sample),
        .i_re      (accept),
        .i_raddr_a (ago_addr(r_wr_pos, s_len)),
        .i_raddr_b (ago_addr(r_wr_pos, l_len)),
        .o_rdata_a (rd_short),
        .o_rdata_b (rd_long)
    );

    // Stage 1: window sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv1) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample  <= i_sample;
            r_s1_restart <= i_restart;
        end
    end

    always_comb begin
        base_short = r_s1_restart ? '0 : r_short_sum;
        base_long  = r_s1_restart ? '0 : r_long_sum;
        base_seen  = r_s1_restart ? '0 : r_seen;
        drop_short = (base_seen >= s_len) ? (SUM_W+1)'($signed(rd_short)) : '0;
        drop_long  = (base_seen >= l_len) ? (SUM_W+1)'($signed(rd_long)) : '0;
        ext_short  = (SUM_W+1)'(base_short) + (SUM_W+1)'(r_s1_sample) - drop_short;
        ext_long   = (SUM_W+1)'(base_long) + (SUM_W+1)'(r_s1_sample) - drop_long;
        n_short_sum = ext_short[SUM_W-1:0];
        n_long_sum  = ext_long[SUM_W-1:0];
        n_seen      = (base_seen < l_len) ? base_seen + LEN_W'(1) : base_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_sum <= '0;
            r_long_sum  <= '0;
            r_seen      <= '0;
        end else if (clear_seq) begin
            r_short_sum <= '0;
            r_long_sum  <= '0;
            r_seen      <= '0;
        end else if (move1) begin
            r_short_sum <= n_short_sum;
            r_long_sum  <= n_long_sum;
            r_seen      <= n_seen;
        end
    end

    // Stage 2: mean comparison and crossing count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move1) begin
            r_s2_short   <= n_short_sum;
            r_s2_long    <= n_long_sum;
            r_s2_full    <= (n_seen >= l_len);
            r_s2_restart <= r_s1_restart;
        end
    end

    assign s_len_s = $signed({1'b0, s_len});
    assign l_len_s = $signed({1'b0, l_len});

    always_comb begin
        lhs = r_s2_short * l_len_s;
        rhs = r_s2_long * s_len_s;
        if (lhs > rhs) begin
            cmp_rel = REL_ABOVE;
        end else if (lhs < rhs) begin
            cmp_rel = REL_BELOW;
        end else begin
            cmp_rel = REL_EQUAL;
        end
        n_rel      = r_s2_full ? cmp_rel : REL_NONE;
        prev_rel   = r_s2_restart ? REL_NONE : r_prev_rel;
        base_count = r_s2_restart ? '0 : r_count;
        n_crossed  = (prev_rel == REL_ABOVE && n_rel == REL_BELOW) ||
                     (prev_rel == REL_BELOW && n_rel == REL_ABOVE);
        n_count    = (n_crossed && base_count != '1) ? base_count + COUNT_BITS'(1) : base_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_rel <= REL_NONE;
            r_count    <= '0;
        end else begin
            if (clear_seq) begin
                r_prev_rel <= REL_NONE;
            end else if (move2) begin
                r_prev_rel <= n_rel;
            end
            if (move2) begin
                r_count <= n_count;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv_o) begin
            r_o_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move2) begin
            r_o_relation <= n_rel;
            r_o_crossed  <= n_crossed;
            r_o_total    <= n_count;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_relation        = r_o_relation;
    assign o_crossed         = r_o_crossed;
    assign o_crossings_total = r_o_total;

endmodule

// ===== design/mac_checker.sv =====
// Port-level assertions for the moving-average crossover counter, bound to the top level.
module mac_checker
    import mac_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [1:0]            o_relation,
    input logic                  o_crossed,
    input logic [COUNT_BITS-1:0] o_crossings_total
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid in the cycle after reset.");

    a_crossed_strict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_crossed) |-> (o_relation == REL_ABOVE || o_relation == REL_BELOW))
        else $error("Crossing reported without a strict relation.");

    a_crossed_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_crossed) |-> (o_crossings_total != '0))
        else $error("Crossing reported with a zero total.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_relation) && $stable(o_crossed) &&
                                   $stable(o_crossings_total)))
        else $error("Stalled result changed before its transfer.");

endmodule

bind moving_average_crossover_counter mac_checker u_mac_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_relation        (o_relation),
    .o_crossed         (o_crossed),
    .o_crossings_total (o_crossings_total)
);
